// ----- src/signed_word_alu_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the signed word ALU
// Short forms for the clocked, reset-gated checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef SIGNED_WORD_ALU_MACROS_SVH
`define SIGNED_WORD_ALU_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SWA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("signed_word_alu: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define SWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("signed_word_alu: next-cycle check failed");

`endif

// ----- src/swa_pkg.sv -----
// ----------------------------------------------------------------------------
// swa_pkg
// Types and constants shared by the signed word ALU modules.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int WORD_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [PROD_BITS-1:0] wide_t;

    localparam word_t MOST_NEGATIVE = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_MUL = 3'd1,
        ACT_DIV = 3'd2,
        ACT_AND = 3'd3,
        ACT_OR  = 3'd4,
        ACT_NOT = 3'd5,
        ACT_SHL = 3'd6,
        ACT_SHR = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } state_t;

    typedef struct packed {
        action_t                     action;
        logic signed [WORD_BITS-1:0] operand_a;
        logic signed [WORD_BITS-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result;
        logic                        overflow;
        logic                        divide_by_zero;
    } rsp_t;

    typedef struct packed {
        wide_t x;
        wide_t y;
        logic  sub;
    } addsub_req_t;

endpackage

// ----- src/swa_addsub.sv -----
// ----------------------------------------------------------------------------
// swa_addsub
// Shared double-width adder/subtractor used by the add, multiply, divide and sign fix-up steps.
// ----------------------------------------------------------------------------
module swa_addsub
    import swa_pkg::*;
(
    input  addsub_req_t cmd,
    output wide_t       sum
);

    wide_t y_eff;

    // Subtract as add of the inverted operand plus one
    assign y_eff = cmd.y ^ {PROD_BITS{cmd.sub}};
    assign sum   = cmd.x + y_eff + wide_t'(cmd.sub);

endmodule

// ----- src/swa_logic.sv -----
// ----------------------------------------------------------------------------
// swa_logic
// Bitwise operations and logical shifts on one word.
// ----------------------------------------------------------------------------
module swa_logic
    import swa_pkg::*;
(
    input  action_t action,
    input  word_t   a,
    input  word_t   b,
    output word_t   result
);

    logic [CNT_BITS-1:0] shamt;
    logic                too_far;

    assign shamt   = b[CNT_BITS-1:0];
    assign too_far = (b >= word_t'(WORD_BITS));

    always_comb
    begin
        case (action)
            ACT_AND: result = a & b;
            ACT_OR:  result = a | b;
            ACT_NOT: result = ~a;
            ACT_SHL: result = too_far ? '0 : (a << shamt);
            ACT_SHR: result = too_far ? '0 : (a >> shamt);
            default: result = '0;
        endcase
    end

endmodule

// ----- src/signed_word_alu.sv -----
// ----------------------------------------------------------------------------
// signed_word_alu
// Signed word ALU with an overflow flag held across logic operations and a multi-cycle mul/div.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall/req) carries action, operand_a and
//   operand_b; a transfer happens when req_valid is high and req_stall low.
//   Response channel (rsp_valid/rsp_stall/rsp) carries result, overflow and
//   divide_by_zero, one response per request, in order.
//   One item at a time: req_stall is high from the transfer until the block
//   is back in idle. Add and the logic/shift operations pass through the
//   execute state; multiply and divide run one step per cycle for 16 steps
//   through the single shared adder, and divide then does the sign fix-up
//   through that adder. Divide by zero and the minimum divided by -1 skip
//   the iteration.
//   A finished response sits in an output register; the block accepts the
//   next request while it waits. If the receiver stalls and a new result is
//   ready, the block holds that result until the register frees up.
//   Reset clears the overflow flag, the sequencer and the response valid.
// ----------------------------------------------------------------------------
`include "signed_word_alu_macros.svh"

module signed_word_alu
    import swa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t              state_reg, state_next;
    action_t             op_reg;
    wide_t               a_reg;
    word_t               b_reg;
    word_t               q_reg;
    wide_t               acc_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                neg_reg;
    word_t               res_reg;
    logic                ovf_res_reg;
    logic                upd_reg;
    logic                dz_reg;
    logic                flag_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    addsub_req_t         add_cmd;
    wide_t               sum;
    word_t               logic_res;
    word_t               in_a;
    word_t               in_b;
    word_t               abs_a;
    word_t               abs_b;
    logic                b_zero;
    logic                min_by_m1;
    logic                last_step;
    logic                out_free;
    wide_t               trial;
    wide_t               prod;
    logic                flag_new;

    swa_addsub u_addsub
    (
        .cmd (add_cmd),
        .sum (sum)
    );

    swa_logic u_logic
    (
        .action (op_reg),
        .a      (a_reg[WORD_BITS-1:0]),
        .b      (b_reg),
        .result (logic_res)
    );

    assign in_a      = word_t'(req.operand_a);
    assign in_b      = word_t'(req.operand_b);
    assign abs_a     = in_a[WORD_BITS-1] ? (~in_a + word_t'(1)) : in_a;
    assign abs_b     = in_b[WORD_BITS-1] ? (~in_b + word_t'(1)) : in_b;
    assign b_zero    = (in_b == '0);
    assign min_by_m1 = (in_a == MOST_NEGATIVE) && (in_b == '1);
    assign last_step = (cnt_reg == CNT_BITS'(WORD_BITS - 1));
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign trial     = {acc_reg[PROD_BITS-2:0], q_reg[WORD_BITS-1]};
    assign prod      = b_reg[0] ? sum : acc_reg;
    assign flag_new  = upd_reg ? ovf_res_reg : flag_reg;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer: next state and operand selection for the shared adder
    always_comb
    begin
        state_next  = state_reg;
        add_cmd     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.action)
                        ACT_MUL: state_next = ST_MUL;
                        ACT_DIV: state_next = (b_zero || min_by_m1) ? ST_DONE : ST_DIV;
                        default: state_next = ST_EXEC;
                    endcase
                end
            end
            ST_EXEC:
            begin
                add_cmd.x  = a_reg;
                add_cmd.y  = {{WORD_BITS{b_reg[WORD_BITS-1]}}, b_reg};
                state_next = ST_DONE;
            end
            ST_MUL:
            begin
                // The sign bit of the multiplier carries negative weight
                add_cmd.x   = acc_reg;
                add_cmd.y   = a_reg;
                add_cmd.sub = last_step;
                if (last_step)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                add_cmd.x   = trial;
                add_cmd.y   = {{WORD_BITS{1'b0}}, b_reg};
                add_cmd.sub = 1'b1;
                if (last_step)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                add_cmd.y   = {{WORD_BITS{1'b0}}, q_reg};
                add_cmd.sub = neg_reg;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            flag_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
            begin
                flag_reg      <= flag_new;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_reg      <= req.action;
                    a_reg       <= {{WORD_BITS{in_a[WORD_BITS-1]}}, in_a};
                    b_reg       <= (req.action == ACT_DIV) ? abs_b : in_b;
                    q_reg       <= abs_a;
                    neg_reg     <= in_a[WORD_BITS-1] ^ in_b[WORD_BITS-1];
                    acc_reg     <= '0;
                    cnt_reg     <= '0;
                    dz_reg      <= (req.action == ACT_DIV) && b_zero;
                    upd_reg     <= (req.action == ACT_ADD) || (req.action == ACT_MUL)
                                   || ((req.action == ACT_DIV) && !b_zero);
                    // Early-out divide results; the iterative paths overwrite these
                    ovf_res_reg <= min_by_m1;
                    res_reg     <= b_zero ? '0 : in_a;
                end
            end
            ST_EXEC:
            begin
                res_reg     <= (op_reg == ACT_ADD) ? sum[WORD_BITS-1:0] : logic_res;
                ovf_res_reg <= sum[WORD_BITS] ^ sum[WORD_BITS-1];
            end
            ST_MUL:
            begin
                acc_reg <= prod;
                a_reg   <= a_reg << 1;
                b_reg   <= b_reg >> 1;
                cnt_reg <= cnt_reg + CNT_BITS'(1);
                if (last_step)
                begin
                    res_reg     <= prod[WORD_BITS-1:0];
                    ovf_res_reg <= !((&prod[PROD_BITS-1:WORD_BITS-1])
                                     || !(|prod[PROD_BITS-1:WORD_BITS-1]));
                end
            end
            ST_DIV:
            begin
                // Restore on a negative trial remainder
                acc_reg <= sum[PROD_BITS-1] ? trial : sum;
                q_reg   <= {q_reg[WORD_BITS-2:0], !sum[PROD_BITS-1]};
                cnt_reg <= cnt_reg + CNT_BITS'(1);
            end
            ST_FIX:
            begin
                res_reg     <= sum[WORD_BITS-1:0];
                ovf_res_reg <= 1'b0;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_reg.result         <= res_reg;
                    rsp_reg.overflow       <= flag_new;
                    rsp_reg.divide_by_zero <= dz_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    `SWA_ASSERT_IMP(a_dz_zero_result, clk, rst_n, rsp_valid && rsp.divide_by_zero, rsp.result == '0)
    `SWA_ASSERT_IMP(a_dz_only_divide, clk, rst_n, (state_reg == ST_DONE) && dz_reg, (op_reg == ACT_DIV) && !upd_reg)
    `SWA_ASSERT_NEXT(a_flag_only_done, clk, rst_n, state_reg != ST_DONE, $stable(flag_reg))
    `SWA_ASSERT_NEXT(a_mul_starts, clk, rst_n, req_valid && !req_stall && (req.action == ACT_MUL), (state_reg == ST_MUL) && (cnt_reg == '0))

endmodule

// ----- bench/alu_result_checker.sv -----
// ----------------------------------------------------------------------------
// alu_result_checker
// Watches the request and response channels of the signed word ALU. It
// computes the expected response of every accepted request, including the
// overflow flag held across logic operations, and compares each response field by field, in order.
// ----------------------------------------------------------------------------
module alu_result_checker
    import swa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding
);

    localparam int REPORT_LIMIT = 10;

    logic sticky_ovf;
    rsp_t pending_results[$];

    function automatic bit out_of_word(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (WORD_BITS - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) || (v < lo);
    endfunction

    // Compute one response and advance the overflow flag
    function automatic rsp_t compute_alu_result(input req_t op);
        rsp_t   r;
        longint sa;
        longint sb;
        longint full;
        word_t  ua;
        word_t  ub;
        sa = op.operand_a;
        sb = op.operand_b;
        ua = op.operand_a;
        ub = op.operand_b;
        r  = '0;
        case (op.action)
            ACT_ADD:
            begin
                full = sa + sb;
                sticky_ovf = out_of_word(full);
                r.result = full[WORD_BITS-1:0];
            end
            ACT_MUL:
            begin
                full = sa * sb;
                sticky_ovf = out_of_word(full);
                r.result = full[WORD_BITS-1:0];
            end
            ACT_DIV:
            begin
                if (sb == 0)
                begin
                    r.divide_by_zero = 1'b1;
                end
                else if (ua == MOST_NEGATIVE && sb == -1)
                begin
                    sticky_ovf = 1'b1;
                    r.result = ua;
                end
                else
                begin
                    sticky_ovf = 1'b0;
                    full = sa / sb;
                    r.result = full[WORD_BITS-1:0];
                end
            end
            ACT_AND: r.result = ua & ub;
            ACT_OR:  r.result = ua | ub;
            ACT_NOT: r.result = ~ua;
            ACT_SHL: r.result = (ub >= WORD_BITS) ? '0 : (ua << ub);
            ACT_SHR: r.result = (ub >= WORD_BITS) ? '0 : (ua >> ub);
            default: r.result = '0;
        endcase
        r.overflow = sticky_ovf;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            sticky_ovf = 1'b0;
            pending_results.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            // Retire before queueing: a response never answers a same-cycle request
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("[%0t] unexpected response: result=%0d ovf=%b dz=%b",
                                 $realtime, rsp.result, rsp.overflow, rsp.divide_by_zero);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.result !== want.result || rsp.overflow !== want.overflow
                        || rsp.divide_by_zero !== want.divide_by_zero)
                    begin
                        if (mismatches < REPORT_LIMIT)
                            $display("[%0t] exp res=%0d ovf=%b dz=%b, got res=%0d ovf=%b dz=%b",
                                     $realtime, want.result, want.overflow,
                                     want.divide_by_zero, rsp.result, rsp.overflow,
                                     rsp.divide_by_zero);
                        mismatches++;
                    end
                end
            end
            if (req_valid && !req_stall)
                pending_results.push_back(compute_alu_result(req));
            outstanding <= pending_results.size();
        end
    end

endmodule

// ----- bench/tb_signed_word_alu.sv -----
// ----------------------------------------------------------------------------
// tb_signed_word_alu
// Drives the signed word ALU with directed corner cases and then random
// operations in bursts, while the response side stalls on its own pattern.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_signed_word_alu;
    import swa_pkg::*;

    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    req_t req       = '0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;
    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;
    int   burst_left  = 0;
    int   stall_mode  = 0;
    int   stall_left  = 0;

    signed_word_alu uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    alu_result_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Response stall: switch between quiet, light, heavy and periodic stretches
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 99) < 30);
            2:       rsp_stall <= ($urandom_range(0, 99) < 75);
            default: rsp_stall <= cycle_count[2];
        endcase
    end

    function automatic req_t make_op(input action_t act, input int a, input int b);
        req_t r;
        r.action    = act;
        r.operand_a = a[WORD_BITS-1:0];
        r.operand_b = b[WORD_BITS-1:0];
        return r;
    endfunction

    function automatic word_t random_operand();
        word_t v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       v = MOST_NEGATIVE;
                    1:       v = ~MOST_NEGATIVE;
                    2:       v = '0;
                    3:       v = word_t'(1);
                    default: v = '1;
                endcase
            end
            1, 2:    v = word_t'(int'($urandom_range(0, 32)) - 16);
            default: v = word_t'($urandom);
        endcase
        return v;
    endfunction

    function automatic req_t random_op();
        req_t r;
        r.action    = action_t'($urandom_range(0, 7));
        r.operand_a = random_operand();
        r.operand_b = random_operand();
        case (r.action)
            ACT_SHL, ACT_SHR:
            begin
                if ($urandom_range(0, 4) != 0)
                    r.operand_b = word_t'($urandom_range(0, WORD_BITS + 2));
            end
            ACT_DIV:
            begin
                case ($urandom_range(0, 9))
                    0: r.operand_b = '0;
                    1:
                    begin
                        r.operand_b = '1;
                        if ($urandom_range(0, 1) == 1)
                            r.operand_a = MOST_NEGATIVE;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    // Hold the request until it transfers; open a gap between bursts
    task automatic send_op(input req_t item);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
        end
        burst_left--;
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
    endtask

    // Drop valid and wait until every response has come back
    task automatic drain_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        burst_left = $urandom_range(1, 16);
    endtask

    initial
    begin
        req_t directed_ops[$];
        int   i;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_ops.push_back(make_op(ACT_ADD, 32767, 1));
        directed_ops.push_back(make_op(ACT_AND, 16'hF0F0, 16'h0FFF));
        directed_ops.push_back(make_op(ACT_DIV, 1234, 0));
        directed_ops.push_back(make_op(ACT_ADD, -1, 1));
        directed_ops.push_back(make_op(ACT_ADD, -32768, -32768));
        directed_ops.push_back(make_op(ACT_ADD, 32767, -32768));
        directed_ops.push_back(make_op(ACT_MUL, 32767, 32767));
        directed_ops.push_back(make_op(ACT_OR, 16'h8001, 16'h0F00));
        directed_ops.push_back(make_op(ACT_MUL, -32768, -1));
        directed_ops.push_back(make_op(ACT_MUL, -181, 181));
        directed_ops.push_back(make_op(ACT_MUL, -32768, 1));
        directed_ops.push_back(make_op(ACT_DIV, -32768, -1));
        directed_ops.push_back(make_op(ACT_NOT, 16'h5A5A, -1));
        directed_ops.push_back(make_op(ACT_DIV, 7, -2));
        directed_ops.push_back(make_op(ACT_DIV, -7, 2));
        directed_ops.push_back(make_op(ACT_DIV, -32768, 1));
        directed_ops.push_back(make_op(ACT_DIV, 5, 0));
        directed_ops.push_back(make_op(ACT_SHL, 1, 15));
        directed_ops.push_back(make_op(ACT_SHL, -1, 0));
        directed_ops.push_back(make_op(ACT_SHL, -1, 16));
        directed_ops.push_back(make_op(ACT_SHL, 1, -1));
        directed_ops.push_back(make_op(ACT_SHR, -32768, 15));
        directed_ops.push_back(make_op(ACT_SHR, -1, 1));
        directed_ops.push_back(make_op(ACT_SHR, -1, 16));
        directed_ops.push_back(make_op(ACT_SHR, 16'h1234, -32768));

        foreach (directed_ops[k])
            send_op(directed_ops[k]);
        drain_results();

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            send_op(random_op());
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
